// ----- design/ils_pkg.sv -----
// Shared definitions for the indexed list store: capacity, derived widths,
// request and status codes, decoded operation type and controller command.
// No dependencies.
package ils_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_READ    = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_NEXT    = 3'd3;
    localparam logic [2:0] REQ_RESTART = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_READ,
        OP_REMOVE,
        OP_NEXT,
        OP_RESTART,
        OP_BAD
    } op_t;

    typedef struct packed {
        logic exec;
        op_t  op;
    } cmd_t;

endpackage

// ----- design/indexed_list_store_core.sv -----
// Channel   Valid      Stall      Payload
// request   req_valid  req_stall  req_type, item_value, item_index
// response  rsp_valid  rsp_stall  read_value, status, entry_count
//
// One transaction per cycle unless stalled: a request is executed in the cycle
// it is taken and its response sits in the result register from the next cycle.
// Removal shifts every cell above the index down in that same cycle.
// rst_n clears count, cursor and controller; entry cells are not reset.
// A request is stalled only while a held response is itself stalled.
// Depends on ils_pkg, ils_ctrl and ils_datapath.
module indexed_list_store_core
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [2:0]               req_type,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [IDX_W-1:0]         item_index,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic signed [DATA_W-1:0] read_value,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count
);

    cmd_t cmd;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    ils_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_value  (item_value),
        .item_index  (item_index),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

// ----- design/ils_ctrl.sv -----
// Controller for the indexed list store: request decode, handshake and
// result-register occupancy. Depends on ils_pkg.
module ils_ctrl
    import ils_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] req_type,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output cmd_t       cmd
);

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   exec;
    op_t    op;

    assign req_stall = (state_reg == S_HOLD) && rsp_stall;
    assign exec      = req_valid && !req_stall;
    assign rsp_valid = (state_reg == S_HOLD);

    always_comb
    begin
        case (req_type)
            REQ_APPEND:  op = OP_APPEND;
            REQ_READ:    op = OP_READ;
            REQ_REMOVE:  op = OP_REMOVE;
            REQ_NEXT:    op = OP_NEXT;
            REQ_RESTART: op = OP_RESTART;
            default:     op = OP_BAD;
        endcase
    end

    assign cmd.exec = exec;
    assign cmd.op   = op;

    always_comb
    begin
        state_next = state_reg;
        if (exec)
        begin
            state_next = S_HOLD;
        end
        else if ((state_reg == S_HOLD) && !rsp_stall)
        begin
            state_next = S_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/ils_datapath.sv -----
// Datapath for the indexed list store: entry cells with shift-down removal,
// fill count, read cursor and result registers. Depends on ils_pkg.
module ils_datapath
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [IDX_W-1:0]         item_index,
    output logic signed [DATA_W-1:0] read_value,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count
);

    logic signed [DATA_W-1:0] entry_reg  [CAPACITY];
    logic signed [DATA_W-1:0] entry_next [CAPACITY];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         cursor_reg;
    logic [CNT_W-1:0]         cursor_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [CNT_W-1:0]         ecount_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     idx_ok;
    logic                     cur_ok;

    assign rd_addr = (cmd.op == OP_NEXT) ? cursor_reg[IDX_W-1:0] : item_index;
    assign rd_data = entry_reg[rd_addr];
    assign idx_ok  = {{(CNT_W-IDX_W){1'b0}}, item_index} < count_reg;
    assign cur_ok  = cursor_reg < count_reg;

    always_comb
    begin
        entry_next  = entry_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        value_next  = '0;
        status_next = ST_OK;
        case (cmd.op)
            OP_APPEND:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    entry_next[count_reg[IDX_W-1:0]] = item_value;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_READ:
            begin
                if (idx_ok)
                begin
                    value_next = rd_data;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_REMOVE:
            begin
                if (idx_ok)
                begin
                    value_next = rd_data;
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (IDX_W'(i) >= item_index)
                        begin
                            entry_next[i] = entry_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_NEXT:
            begin
                if (cur_ok)
                begin
                    value_next = rd_data;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
                if (cursor_reg < CNT_W'(CAPACITY))
                begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            OP_RESTART:
            begin
                cursor_next = '0;
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            entry_reg  <= entry_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            ecount_reg <= count_next;
        end
    end

    assign read_value  = value_reg;
    assign status      = status_reg;
    assign entry_count = ecount_reg;

endmodule
